FILE: sv/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared constants, types and round functions for the MD5 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none
package md5_pkg;
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int          QUEUE_DEPTH = 4;

    typedef enum logic { ACT_ABSORB = 1'b0, ACT_FINISH = 1'b1 } action_t;

    // Command from front to back: one byte into the block, possibly ending it
    typedef struct packed {
        logic [7:0] data;
        logic [5:0] pos;
        logic       compress;
        logic       emit;
    } md5_cmd_t;

    function automatic logic [31:0] sine_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hD76AA478;  6'd1: k = 32'hE8C7B756;
            6'd2: k = 32'h242070DB;  6'd3: k = 32'hC1BDCEEE;
            6'd4: k = 32'hF57C0FAF;  6'd5: k = 32'h4787C62A;
            6'd6: k = 32'hA8304613;  6'd7: k = 32'hFD469501;
            6'd8: k = 32'h698098D8;  6'd9: k = 32'h8B44F7AF;
            6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
            6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193;
            6'd14: k = 32'hA679438E; 6'd15: k = 32'h49B40821;
            6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
            6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA;
            6'd20: k = 32'hD62F105D; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
            6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6;
            6'd26: k = 32'hF4D50D87; 6'd27: k = 32'h455A14ED;
            6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
            6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A;
            6'd32: k = 32'hFFFA3942; 6'd33: k = 32'h8771F681;
            6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
            6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9;
            6'd38: k = 32'hF6BB4B60; 6'd39: k = 32'hBEBFBC70;
            6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
            6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05;
            6'd44: k = 32'hD9D4D039; 6'd45: k = 32'hE6DB99E5;
            6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
            6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97;
            6'd50: k = 32'hAB9423A7; 6'd51: k = 32'hFC93A039;
            6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
            6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1;
            6'd56: k = 32'h6FA87E4F; 6'd57: k = 32'hFE2CE6E0;
            6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
            6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235;
            6'd62: k = 32'h2AD7D2BB; default: k = 32'hEB86D391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] r;
        case ({i[5:4], i[1:0]})
            4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
            4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
            4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
            4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
        endcase
        return r;
    endfunction

    // Message word index used by step i
    function automatic logic [3:0] word_sel(input logic [5:0] i);
        logic [3:0] w;
        case (i[5:4])
            2'd0: w = i[3:0];
            2'd1: w = 4'(i[3:0] * 4'd5 + 4'd1);
            2'd2: w = 4'(i[3:0] * 4'd3 + 4'd5);
            default: w = 4'(i[3:0] * 4'd7);
        endcase
        return w;
    endfunction
endpackage
`default_nettype wire

FILE: sv/md5_if.sv
// ----------------------------------------------------------------------------
// md5_in_if / md5_out_if
// Valid/ready channels for message items and digest words.
// ----------------------------------------------------------------------------
`default_nettype none
interface md5_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] msg_byte;
    modport source (output valid, action, msg_byte, input ready);
    modport sink (input valid, action, msg_byte, output ready);
endinterface

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

FILE: sv/md5_hash_engine_unit.sv
// ----------------------------------------------------------------------------
// md5_hash_engine_unit
// Byte-serial MD5 hasher: front sequencer, command queue, compression back.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per handshake: action absorb adds msg_byte,
//   action finish pads the message and requests the digest.
//   out_ch returns four digest words per finish, word_index 0..3, with
//   last_word set on the fourth.
// Throughput: one absorb per cycle while the queue has room. Every
//   64th byte starts a compression (prefetch, 64 steps, add) during which
//   the back takes no byte; the queue absorbs up to four.
// Finish: expands into up to 72 padding and length bytes, one per cycle
//   while the queue has room, plus one or two compressions, then the words.
// Reset: chaining words return to the initial values and the byte count
//   to zero; the block RAM holds stale data that is always overwritten.
// Stall: words wait in place while out_ch.ready is low; the back then
//   holds off the queue, and the front stops taking items once it fills.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_hash_engine_unit import md5_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    md5_in_if.sink    in_ch,
    md5_out_if.source out_ch
);
    logic     f_valid, f_ready, b_valid, b_ready;
    md5_cmd_t f_cmd, b_cmd;

    md5_front u_front (
        .clk (clk), .rst_n (rst_n), .in_ch (in_ch),
        .cmd_valid (f_valid), .cmd_ready (f_ready), .cmd (f_cmd)
    );

    md5_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk (clk), .rst_n (rst_n),
        .push_valid (f_valid), .push_ready (f_ready), .push_cmd (f_cmd),
        .pop_valid (b_valid), .pop_ready (b_ready), .pop_cmd (b_cmd)
    );

    md5_back u_back (
        .clk (clk), .rst_n (rst_n),
        .cmd_valid (b_valid), .cmd_ready (b_ready), .cmd (b_cmd),
        .out_ch (out_ch)
    );
endmodule
`default_nettype wire

FILE: sv/md5_ram.sv
// ----------------------------------------------------------------------------
// md5_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: sv/md5_front.sv
// ----------------------------------------------------------------------------
// md5_front
// Accepts items, tracks the byte count and expands a finish item into
// padding and length bytes, one command per cycle while cmd_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_front import md5_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    md5_in_if.sink        in_ch,
    output logic          cmd_valid,
    input  wire logic     cmd_ready,
    output md5_cmd_t      cmd
);
    typedef enum logic [1:0] { S_IDLE, S_PAD, S_LEN } state_t;

    state_t      state_reg, state_next;
    logic [63:0] count_reg, count_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  pos_reg, pos_next;

    assign in_ch.ready = (state_reg == S_IDLE) && cmd_ready;

    // Build the next command and step the sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        bits_next  = bits_reg;
        pos_next   = pos_reg;
        cmd_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_valid = in_ch.valid;
                cmd.pos   = count_reg[5:0];
                cmd.compress = (count_reg[5:0] == 6'd63);
                if (in_ch.action == ACT_FINISH)
                begin
                    cmd.data = PAD_BYTE;
                end
                else
                begin
                    cmd.data = in_ch.msg_byte;
                end
                if (in_ch.valid && cmd_ready)
                begin
                    if (in_ch.action == ACT_FINISH)
                    begin
                        bits_next  = {count_reg[60:0], 3'b000};
                        pos_next   = 6'(count_reg[5:0] + 6'd1);
                        count_next = '0;
                        state_next = (6'(count_reg[5:0] + 6'd1) == 6'd56) ? S_LEN : S_PAD;
                    end
                    else
                    begin
                        count_next = count_reg + 64'd1;
                    end
                end
            end
            S_PAD:
            begin
                cmd_valid    = 1'b1;
                cmd.pos      = pos_reg;
                cmd.compress = (pos_reg == 6'd63);
                if (cmd_ready)
                begin
                    pos_next = 6'(pos_reg + 6'd1);
                    if (6'(pos_reg + 6'd1) == 6'd56)
                    begin
                        state_next = S_LEN;
                    end
                end
            end
            S_LEN:
            begin
                cmd_valid    = 1'b1;
                cmd.pos      = pos_reg;
                cmd.data     = bits_reg[7:0];
                cmd.compress = (pos_reg == 6'd63);
                cmd.emit     = (pos_reg == 6'd63);
                if (cmd_ready)
                begin
                    pos_next  = 6'(pos_reg + 6'd1);
                    bits_next = {8'h00, bits_reg[63:8]};
                    if (pos_reg == 6'd63)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            bits_reg  <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            bits_reg  <= bits_next;
            pos_reg   <= pos_next;
        end
    end
endmodule
`default_nettype wire

FILE: sv/md5_queue.sv
// ----------------------------------------------------------------------------
// md5_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_queue import md5_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire md5_cmd_t push_cmd,
    output logic          pop_valid,
    input  wire logic     pop_ready,
    output md5_cmd_t      pop_cmd
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    md5_cmd_t         slot_reg [DEPTH];
    logic [AW-1:0]    wr_reg, rd_reg;
    logic [AW:0]      fill_reg;
    logic             push, pop;

    assign push_ready = (fill_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = slot_reg[rd_reg];
    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    // Store incoming commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : AW'(wr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : AW'(rd_reg + 1'b1);
            end
            fill_reg <= (AW+1)'(fill_reg + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop});
        end
    end
endmodule
`default_nettype wire

FILE: sv/md5_back.sv
// ----------------------------------------------------------------------------
// md5_back
// Writes bytes into the block RAM, runs the 64-step compression one step
// per cycle and emits the digest words.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_back import md5_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_ready,
    input  wire md5_cmd_t cmd,
    md5_out_if.source     out_ch
);
    typedef enum logic [1:0] { S_FILL, S_RUN, S_ADD, S_EMIT } state_t;

    state_t      state_reg;
    logic [31:0] ca_reg, cb_reg, cc_reg, cd_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [6:0]  step_reg;
    logic        emit_reg;
    logic [1:0]  idx_reg;

    logic        we;
    logic [3:0]  raddr;
    logic [31:0] rdata;
    logic [5:0]  cur;
    logic [31:0] f, t, rot, sum_b;
    logic [4:0]  sh;

    assign cmd_ready = (state_reg == S_FILL);
    assign we = cmd_valid && cmd_ready;

    // Block stored as 16 words, byte-written through four lanes
    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_lane
            md5_ram #(.WIDTH(8), .DEPTH(16)) u_ram (
                .clk   (clk),
                .we    (we && (cmd.pos[1:0] == 2'(g))),
                .waddr (cmd.pos[5:2]),
                .wdata (cmd.data),
                .raddr (raddr),
                .rdata (rdata[8*g +: 8])
            );
        end
    endgenerate

    // Prefetch the word for the next step
    assign raddr = word_sel(6'(step_reg));
    assign cur   = 6'(step_reg - 7'd1);

    // One compression step
    always_comb
    begin
        case (cur[5:4])
            2'd0: f = d_reg ^ (b_reg & (c_reg ^ d_reg));
            2'd1: f = c_reg ^ (d_reg & (b_reg ^ c_reg));
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        t     = a_reg + f + rdata + sine_k(cur);
        sh    = rot_amount(cur);
        rot   = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
        sum_b = rot + b_reg;
    end

    always_comb
    begin
        out_ch.valid       = (state_reg == S_EMIT);
        out_ch.word_index  = idx_reg;
        out_ch.last_word   = (idx_reg == 2'd3);
        case (idx_reg)
            2'd0: out_ch.digest_word = ca_reg;
            2'd1: out_ch.digest_word = cb_reg;
            2'd2: out_ch.digest_word = cc_reg;
            default: out_ch.digest_word = cd_reg;
        endcase
    end

    // Sequence fill, compression, chaining add and emission
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FILL;
            ca_reg <= IV_A; cb_reg <= IV_B; cc_reg <= IV_C; cd_reg <= IV_D;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0;
            step_reg <= '0;
            emit_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_FILL:
                begin
                    if (we && cmd.compress)
                    begin
                        a_reg <= ca_reg; b_reg <= cb_reg;
                        c_reg <= cc_reg; d_reg <= cd_reg;
                        step_reg  <= '0;
                        emit_reg  <= cmd.emit;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    step_reg <= 7'(step_reg + 7'd1);
                    if (step_reg != 7'd0)
                    begin
                        a_reg <= d_reg; d_reg <= c_reg; c_reg <= b_reg; b_reg <= sum_b;
                    end
                    if (step_reg == 7'd64)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    ca_reg <= ca_reg + a_reg; cb_reg <= cb_reg + b_reg;
                    cc_reg <= cc_reg + c_reg; cd_reg <= cd_reg + d_reg;
                    idx_reg   <= '0;
                    state_reg <= emit_reg ? S_EMIT : S_FILL;
                end
                S_EMIT:
                begin
                    if (out_ch.ready)
                    begin
                        idx_reg <= 2'(idx_reg + 2'd1);
                        if (idx_reg == 2'd3)
                        begin
                            ca_reg <= IV_A; cb_reg <= IV_B;
                            cc_reg <= IV_C; cd_reg <= IV_D;
                            state_reg <= S_FILL;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_FILL;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: sv/md5_checker.sv
// ----------------------------------------------------------------------------
// md5_checker
// Port-level checks on the digest channel.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] out_index,
    input wire logic       out_last
);
    // last marks exactly word three
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == (out_index == 2'd3)))
        else $error("last_word mismatch");

    // words advance by one after a taken non-last word
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_last) |=>
            (out_valid && out_index == 2'($past(out_index) + 2'd1)))
        else $error("digest word skipped");

    // a stalled word keeps its index
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_index)))
        else $error("stalled word changed");
endmodule

bind md5_hash_engine_unit md5_checker u_md5_checker (
    .clk (clk), .rst_n (rst_n),
    .out_valid (out_ch.valid), .out_ready (out_ch.ready),
    .out_index (out_ch.word_index), .out_last (out_ch.last_word)
);
`default_nettype wire

FILE: tb/md5_hash_engine_unit_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// md5_hash_engine_unit_chk
// Watches the message and digest channels, hashes every accepted item with
// its own MD5 model and compares each digest word with the oldest one owed.
// ----------------------------------------------------------------------------
module md5_hash_engine_unit_chk import md5_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    md5_in_if         in_ch,
    md5_out_if        out_ch,
    output int        fail_count,
    output int        words_owed,
    output int        digests_seen
);
    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  idx;
        logic        last;
    } digest_word_t;

    digest_word_t owed_words[$];
    logic [31:0]  chain[4];
    logic [7:0]   blk[64];
    logic [63:0]  msg_len;

    localparam logic [31:0] K_TAB[64] = '{
        32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
        32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
        32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
        32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
        32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
        32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
        32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
        32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
        32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
        32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
        32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
        32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
        32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
        32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
        32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
        32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
    };
    localparam int SHIFTS[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                  6, 10, 15, 21};

    // Run the 64 steps over the block and fold the result into the chain
    function automatic void compress();
        logic [31:0] m[16];
        logic [31:0] a, b, c, d, f, t;
        int w;
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int i = 0; i < 16; i++)
            m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        for (int i = 0; i < 64; i++)
        begin
            case (i / 16)
                0: begin f = d ^ (b & (c ^ d)); w = i; end
                1: begin f = c ^ (d & (b ^ c)); w = (5*i + 1) % 16; end
                2: begin f = b ^ c ^ d; w = (3*i + 5) % 16; end
                default: begin f = c ^ (b | ~d); w = (7*i) % 16; end
            endcase
            t = a + f + m[w] + K_TAB[i];
            t = ((t << SHIFTS[(i/16)*4 + i%4]) | (t >> (32 - SHIFTS[(i/16)*4 + i%4]))) + b;
            a = d; d = c; c = b; b = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endfunction

    function automatic int put_byte(int pos, logic [7:0] v);
        blk[pos] = v;
        pos++;
        if (pos == 64)
        begin
            compress();
            pos = 0;
        end
        return pos;
    endfunction

    function automatic void restart_message();
        chain[0] = IV_A; chain[1] = IV_B; chain[2] = IV_C; chain[3] = IV_D;
        msg_len = '0;
    endfunction

    // Pad, append the bit length and queue the four digest words
    function automatic void close_message();
        logic [63:0] bits;
        int pos;
        bits = msg_len << 3;
        pos = put_byte(int'(msg_len[5:0]), PAD_BYTE);
        while (pos != 56)
            pos = put_byte(pos, 8'h00);
        for (int i = 0; i < 8; i++)
            pos = put_byte(pos, bits[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            owed_words.push_back('{chain[i], 2'(i), i == 3});
        restart_message();
    endfunction

    initial
    begin
        restart_message();
        fail_count = 0;
        digests_seen = 0;
    end

    assign words_owed = owed_words.size();

    // Predict on input items, compare on output items
    always @(posedge clk)
    begin
        digest_word_t exp_w;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (owed_words.size() == 0)
                begin
                    $error("digest word with none owed: %h", out_ch.digest_word);
                    fail_count++;
                end
                else
                begin
                    exp_w = owed_words.pop_front();
                    if (out_ch.digest_word !== exp_w.word)
                    begin
                        $error("digest_word expected %h got %h", exp_w.word,
                               out_ch.digest_word);
                        fail_count++;
                    end
                    if (out_ch.word_index !== exp_w.idx)
                    begin
                        $error("word_index expected %0d got %0d", exp_w.idx,
                               out_ch.word_index);
                        fail_count++;
                    end
                    if (out_ch.last_word !== exp_w.last)
                    begin
                        $error("last_word expected %0d got %0d", exp_w.last,
                               out_ch.last_word);
                        fail_count++;
                    end
                    if (exp_w.last)
                        digests_seen++;
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (action_t'(in_ch.action) == ACT_FINISH)
                    close_message();
                else
                begin
                    blk[msg_len[5:0]] = in_ch.msg_byte;
                    if (msg_len[5:0] == 6'd63)
                        compress();
                    msg_len++;
                end
            end
        end
    end
endmodule

FILE: tb/md5_hash_engine_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// md5_hash_engine_unit_tb
// Feeds messages of many lengths (block edges, empty, long) through the
// hasher under varying idle patterns; the checker compares every digest.
// ----------------------------------------------------------------------------
module md5_hash_engine_unit_tb;
    import md5_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count, words_owed, digests_seen;
    int   cycles = 0;
    int   send_idle = 0;
    int   recv_idle = 0;
    int   items_sent = 0;

    md5_in_if  in_ch();
    md5_out_if out_ch();

    md5_hash_engine_unit u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

    md5_hash_engine_unit_chk u_chk (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .fail_count(fail_count), .words_owed(words_owed), .digests_seen(digests_seen)
    );

    always #5 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.action = ACT_ABSORB;
        in_ch.msg_byte = '0;
        out_ch.ready = 1'b0;
    end

    // Stall the digest side at the current rate
    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_idle);

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("md5_hash_engine_unit_tb NOT OK");
            $finish;
        end
    end

    // Offer one item and hold it until taken
    task automatic send_item(action_t act, logic [7:0] b);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.msg_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_message(int len, int pattern);
        for (int i = 0; i < len; i++)
            case (pattern)
                0: send_item(ACT_ABSORB, 8'h00);
                1: send_item(ACT_ABSORB, 8'hFF);
                default: send_item(ACT_ABSORB, 8'($urandom));
            endcase
        send_item(ACT_FINISH, 8'($urandom));
    endtask

    // Pick a length, biased toward block and padding edges
    function automatic int pick_len();
        int edges[8] = '{0, 55, 56, 63, 64, 119, 120, 128};
        case ($urandom_range(3))
            0: return edges[$urandom_range(7)];
            1: return edges[$urandom_range(7)] + $urandom_range(2);
            default: return $urandom_range(20);
        endcase
    endfunction

    initial
    begin
        int n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty, single bytes at the extremes, padding edges
        send_message(0, 0);
        send_message(1, 0);
        send_message(1, 1);
        send_message(3, 2);
        send_message(2, 1);
        send_message(55, 2);
        send_message(56, 2);
        send_message(64, 1);

        // Hold back until every digest word has come
        in_ch.valid <= 1'b0;
        while (words_owed != 0)
            @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 34 : (phase == 1) ? 80 : 0;
            recv_idle = (phase == 0) ? 80 : (phase == 1) ? 34 : 0;
            n = items_sent;
            while (items_sent - n < 50)
                send_message(pick_len(), 2);
        end
        in_ch.valid <= 1'b0;

        while (words_owed != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Sent %0d items; %0d digests checked across idle patterns.",
                 items_sent, digests_seen);
        if (fail_count == 0 && words_owed == 0)
            $display("md5_hash_engine_unit_tb OK");
        else
            $display("md5_hash_engine_unit_tb NOT OK");
        $finish;
    end
endmodule

FILE: files.f
sv/md5_pkg.sv
sv/md5_if.sv
sv/md5_ram.sv
sv/md5_front.sv
sv/md5_queue.sv
sv/md5_back.sv
sv/md5_hash_engine_unit.sv
sv/md5_checker.sv
tb/md5_hash_engine_unit_chk.sv
tb/md5_hash_engine_unit_tb.sv
